// ===== rtl/prp_pkg.sv =====
package prp_pkg;

  // coordinate format, shared by vertices, normal and anchor
  localparam int CW        = 32;
  localparam int FRAC_BITS = 16;

  // derived arithmetic widths
  localparam int DW    = CW + 1;              // vertex minus anchor
  localparam int PW    = CW + DW;             // normal times difference
  localparam int DOTW  = PW + 2;              // sum of three products
  localparam int LOW_W = (DOTW + 1) / 2;      // low slice of |dot| for the split multiply
  localparam int HIW   = DOTW - LOW_W;        // high slice of |dot|
  localparam int PRODW = DOTW + CW;           // |dot| * |n_i|
  localparam int NSQW  = 2 * CW;              // n_i squared
  localparam int NNW   = NSQW + 2;            // n.n
  localparam int DENW  = NNW + 1;             // divisor 2*n.n
  localparam int QW    = CW + 3;              // rounded offset magnitude
  localparam int NUMW  = DENW + QW;           // dividend

  // register file
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;
  localparam int IDX_W  = ADDR_W - 2;

  localparam logic [IDX_W-1:0] REG_NORMAL_X    = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_NORMAL_Y    = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_NORMAL_Z    = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_ANCHOR_X    = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_ANCHOR_Y    = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_ANCHOR_Z    = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_PROJECT_MODE = IDX_W'(6);

  localparam logic [CW-1:0] NORMAL_Z_RST = CW'(64'd1 << FRAC_BITS);

  // per-lane data that rides along with the divider
  typedef struct packed {
    logic signed [CW-1:0] p;
    logic                 qneg;
  } lane_side_t;

endpackage

// ===== rtl/prp_div_lane.sv =====
module prp_div_lane (
  input  logic                     clk,
  input  logic                     en,
  input  logic [prp_pkg::DENW-1:0] den,
  input  logic [prp_pkg::NUMW-1:0] num,
  input  prp_pkg::lane_side_t      side_in,
  output logic [prp_pkg::QW-1:0]   quo,
  output prp_pkg::lane_side_t      side_out
);
  import prp_pkg::*;

  // one quotient bit per stage; the low dividend bits shift out on the left
  // while quotient bits shift in on the right
  logic [DENW-1:0] rem_r  [QW];
  logic [QW-1:0]   lq_r   [QW];
  lane_side_t      side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DENW-1:0] rem_in;
    logic [QW-1:0]   lq_in;
    lane_side_t      side_k;
    logic [DENW:0]   trial;
    logic            fits;
    logic [DENW-1:0] rem_nxt;
    logic [QW-1:0]   lq_nxt;

    if (k == 0) begin : g_first
      assign rem_in = num[NUMW-1:QW];
      assign lq_in  = num[QW-1:0];
      assign side_k = side_in;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign lq_in  = lq_r[k-1];
      assign side_k = side_r[k-1];
    end

    always_comb begin
      trial   = {rem_in, lq_in[QW-1]};
      fits    = (trial >= {1'b0, den});
      rem_nxt = fits ? DENW'(trial - {1'b0, den}) : trial[DENW-1:0];
      lq_nxt  = {lq_in[QW-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        lq_r[k]   <= lq_nxt;
        side_r[k] <= side_k;
      end
    end
  end

  assign quo      = lq_r[QW-1];
  assign side_out = side_r[QW-1];

endmodule

// ===== rtl/plane_reflect_project_core.sv =====
// Reflects each vertex across the configured plane, or projects it onto the
// plane, in signed Q16.16. One vertex enters per clock while in_stall is low:
// 7 stages form the difference, dot product and dividend, 35 stages form a
// restoring divider by 2*n.n that yields one quotient bit per stage, and one
// stage applies the offset and clips. A stall on the output holds the whole
// pipeline while a result waits there. Offsets round to nearest with ties away
// from zero. A zero normal passes the vertex through and sets degenerate_plane;
// a clipped coordinate sets saturated. Write the plane registers only while no
// vertex is in flight.
module plane_reflect_project_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // vertex input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [prp_pkg::CW-1:0] in_vertex_x,
  input  logic signed [prp_pkg::CW-1:0] in_vertex_y,
  input  logic signed [prp_pkg::CW-1:0] in_vertex_z,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [prp_pkg::CW-1:0] out_x,
  output logic signed [prp_pkg::CW-1:0] out_y,
  output logic signed [prp_pkg::CW-1:0] out_z,
  output logic                        out_saturated,
  output logic                        out_degenerate_plane,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prp_pkg::ADDR_W-1:0]  paddr,
  input  logic [prp_pkg::DATA_W-1:0]  pwdata,
  output logic [prp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import prp_pkg::*;

  localparam int FRONT = 7;
  localparam int NPIPE = FRONT + QW + 1;
  localparam int RW    = QW + 2;
  localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

  // ---------------- registers ----------------
  logic signed [CW-1:0] norm_r [3];
  logic signed [CW-1:0] anch_r [3];
  logic                 mode_r;
  logic [IDX_W-1:0]     idx;
  logic                 wr;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r[0] <= '0;
      norm_r[1] <= '0;
      norm_r[2] <= NORMAL_Z_RST;
      anch_r[0] <= '0;
      anch_r[1] <= '0;
      anch_r[2] <= '0;
      mode_r    <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_NORMAL_X:     norm_r[0] <= pwdata[CW-1:0];
        REG_NORMAL_Y:     norm_r[1] <= pwdata[CW-1:0];
        REG_NORMAL_Z:     norm_r[2] <= pwdata[CW-1:0];
        REG_ANCHOR_X:     anch_r[0] <= pwdata[CW-1:0];
        REG_ANCHOR_Y:     anch_r[1] <= pwdata[CW-1:0];
        REG_ANCHOR_Z:     anch_r[2] <= pwdata[CW-1:0];
        REG_PROJECT_MODE: mode_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NORMAL_X:     prdata = DATA_W'(norm_r[0]);
      REG_NORMAL_Y:     prdata = DATA_W'(norm_r[1]);
      REG_NORMAL_Z:     prdata = DATA_W'(norm_r[2]);
      REG_ANCHOR_X:     prdata = DATA_W'(anch_r[0]);
      REG_ANCHOR_Y:     prdata = DATA_W'(anch_r[1]);
      REG_ANCHOR_Z:     prdata = DATA_W'(anch_r[2]);
      REG_PROJECT_MODE: prdata = DATA_W'(mode_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------- plane constants ----------------
  logic [CW-1:0]   nmag [3];
  logic [NSQW-1:0] sq_r [3];
  logic [NNW-1:0]  nn_r;
  logic            deg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag[i] = norm_r[i][CW-1] ? CW'(-norm_r[i]) : CW'(norm_r[i]);
    end
    deg = (norm_r[0] == '0) && (norm_r[1] == '0) && (norm_r[2] == '0);
  end

  // n.n follows the registers through sq_r and then nn_r, before any vertex needs it
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= nmag[i] * nmag[i];
    end
    nn_r <= NNW'(sq_r[0]) + NNW'(sq_r[1]) + NNW'(sq_r[2]);
  end

  // ---------------- pipeline control ----------------
  logic [NPIPE-1:0] vld_r;
  logic             en;

  assign en       = !vld_r[NPIPE-1] || !out_stall;
  assign in_stall = !en;
  assign out_valid = vld_r[NPIPE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NPIPE-2:0], in_valid};
    end
  end

  // ---------------- front stages ----------------
  logic signed [CW-1:0]   vin [3];
  logic signed [CW-1:0]   p1_r [3], p2_r [3], p3_r [3], p4_r [3];
  logic signed [CW-1:0]   p5_r [3], p6_r [3], p7_r [3];
  logic signed [DW-1:0]   d1_r [3];
  logic signed [PW-1:0]   pr2_r [3];
  logic signed [DOTW-1:0] dot3_r;
  logic [DOTW-1:0]        mdot4_r;
  logic                   neg4_r, neg5_r;
  logic [LOW_W+CW-1:0]    lo5_r [3];
  logic [HIW+CW-1:0]      hi5_r [3];
  logic [PRODW-1:0]       prod6_r [3];
  logic                   qneg6_r [3], qneg7_r [3];
  logic [NUMW-1:0]        num7_r [3];

  assign vin[0] = in_vertex_x;
  assign vin[1] = in_vertex_y;
  assign vin[2] = in_vertex_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[i]   <= vin[i];
        d1_r[i]   <= DW'(vin[i]) - DW'(anch_r[i]);
        p2_r[i]   <= p1_r[i];
        pr2_r[i]  <= PW'(norm_r[i]) * PW'(d1_r[i]);
        p3_r[i]   <= p2_r[i];
        p4_r[i]   <= p3_r[i];
        p5_r[i]   <= p4_r[i];
        // split |dot| so each multiplier stays near 32 by 32
        lo5_r[i]  <= mdot4_r[LOW_W-1:0] * nmag[i];
        hi5_r[i]  <= mdot4_r[DOTW-1:LOW_W] * nmag[i];
        p6_r[i]   <= p5_r[i];
        prod6_r[i] <= PRODW'(lo5_r[i]) + (PRODW'(hi5_r[i]) << LOW_W);
        qneg6_r[i] <= neg5_r ^ norm_r[i][CW-1];
        p7_r[i]   <= p6_r[i];
        qneg7_r[i] <= qneg6_r[i];
        // 2*k*|dot|*|n_i| + n.n, so the floor below rounds half up
        num7_r[i] <= (mode_r ? (NUMW'(prod6_r[i]) << 1) : (NUMW'(prod6_r[i]) << 2))
                     + NUMW'(nn_r);
      end
      dot3_r  <= DOTW'(pr2_r[0]) + DOTW'(pr2_r[1]) + DOTW'(pr2_r[2]);
      neg4_r  <= dot3_r[DOTW-1];
      mdot4_r <= dot3_r[DOTW-1] ? DOTW'(-dot3_r) : DOTW'(dot3_r);
      neg5_r  <= neg4_r;
    end
  end

  // ---------------- dividers ----------------
  logic [DENW-1:0] den;
  logic [QW-1:0]   quo [3];
  lane_side_t      side_in [3];
  lane_side_t      side_o  [3];

  assign den = {nn_r, 1'b0};

  for (genvar g = 0; g < 3; g++) begin : g_lane
    assign side_in[g].p    = p7_r[g];
    assign side_in[g].qneg = qneg7_r[g];

    prp_div_lane u_div (
      .clk      (clk),
      .en       (en),
      .den      (den),
      .num      (num7_r[g]),
      .side_in  (side_in[g]),
      .quo      (quo[g]),
      .side_out (side_o[g])
    );
  end

  // ---------------- apply offset and clip ----------------
  logic signed [RW-1:0] pw [3];
  logic signed [RW-1:0] qw [3];
  logic signed [RW-1:0] rsum [3];
  logic signed [CW-1:0] res [3];
  logic [2:0]           clip;
  logic signed [CW-1:0] out_x_r, out_y_r, out_z_r;
  logic                 sat_r, deg_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pw[i]   = RW'(side_o[i].p);
      qw[i]   = $signed(RW'(quo[i]));
      rsum[i] = side_o[i].qneg ? (pw[i] + qw[i]) : (pw[i] - qw[i]);
      clip[i] = 1'b0;
      if (deg) begin
        res[i] = side_o[i].p;
      end else if (rsum[i] > SAT_HI) begin
        res[i]  = SAT_HI[CW-1:0];
        clip[i] = 1'b1;
      end else if (rsum[i] < SAT_LO) begin
        res[i]  = SAT_LO[CW-1:0];
        clip[i] = 1'b1;
      end else begin
        res[i] = rsum[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r <= res[0];
      out_y_r <= res[1];
      out_z_r <= res[2];
      sat_r   <= |clip;
      deg_r   <= deg;
    end
  end

  assign out_x                = out_x_r;
  assign out_y                = out_y_r;
  assign out_z                = out_z_r;
  assign out_saturated        = sat_r;
  assign out_degenerate_plane = deg_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import prp_pkg::*;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
    logic   deg;
  } vertex_out_t;

  typedef struct packed {
    coord_t nx;
    coord_t ny;
    coord_t nz;
    coord_t ax;
    coord_t ay;
    coord_t az;
    logic   mode;
  } plane_t;

  typedef struct {
    int          plane_sel;
    coord_t      x;
    coord_t      y;
    coord_t      z;
    bit          known;
    vertex_out_t want;
  } vector_row_t;

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t ONE  = coord_t'(64'd1 << FRAC_BITS);
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RAND_PHASES     = 10;
  localparam int PHASE_ITEMS     = 125;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  coord_t      in_vertex_x;
  coord_t      in_vertex_y;
  coord_t      in_vertex_z;
  logic        out_valid;
  logic        out_stall;
  coord_t      out_x;
  coord_t      out_y;
  coord_t      out_z;
  logic        out_saturated;
  logic        out_degenerate_plane;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic        pready;

  // typed-in expectation that rides along with the offered beat
  logic        row_known;
  vertex_out_t row_want;

  plane_t      plane;
  vertex_out_t moved_vertices[$];
  vector_row_t vector_table[$];
  plane_t      dir_planes[6];
  int          n_bad;
  int          in_gap_pct;
  int          out_hold_pct;
  bit          hold_off_req;
  int          hold_left;
  vertex_out_t got_v;
  vertex_out_t want_v;

  plane_reflect_project_core i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_vertex_x          (in_vertex_x),
    .in_vertex_y          (in_vertex_y),
    .in_vertex_z          (in_vertex_z),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_x                (out_x),
    .out_y                (out_y),
    .out_z                (out_z),
    .out_saturated        (out_saturated),
    .out_degenerate_plane (out_degenerate_plane),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // exact offset k*(n.(p-a))*n_i/(n.n), rounded half away from zero, then clip; a zero normal passes through
  function automatic vertex_out_t reflect_or_project(plane_t pl, coord_t vx, coord_t vy,
                                                     coord_t vz);
    longint            pv[3];
    longint            nv[3];
    longint            av[3];
    longint            nm;
    longint            qv;
    longint            rv;
    longint            hi;
    longint            lo;
    logic signed [95:0] dot;
    logic signed [95:0] term;
    logic [191:0]      nn;
    logic [191:0]      mdot;
    logic [191:0]      num;
    logic [191:0]      quo;
    coord_t            outc[3];
    vertex_out_t       res;
    pv[0] = vx;
    pv[1] = vy;
    pv[2] = vz;
    nv[0] = pl.nx;
    nv[1] = pl.ny;
    nv[2] = pl.nz;
    av[0] = pl.ax;
    av[1] = pl.ay;
    av[2] = pl.az;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    res.sat = 1'b0;
    res.deg = 1'b0;
    nn = '0;
    for (int i = 0; i < 3; i++) begin
      nm = (nv[i] < 0) ? -nv[i] : nv[i];
      nn = nn + 192'(nm) * 192'(nm);
    end
    if (nn == 0) begin
      res.x = vx;
      res.y = vy;
      res.z = vz;
      res.deg = 1'b1;
      return res;
    end
    dot = '0;
    for (int i = 0; i < 3; i++) begin
      term = nv[i] * (pv[i] - av[i]);
      dot = dot + term;
    end
    mdot = (dot < 0) ? -dot : dot;
    for (int i = 0; i < 3; i++) begin
      nm = (nv[i] < 0) ? -nv[i] : nv[i];
      num = mdot * 192'(nm);
      if (!pl.mode) num = num * 2;
      num = 2 * num + nn;
      quo = num / (2 * nn);
      qv = longint'(quo[63:0]);
      if ((dot < 0) != (nv[i] < 0)) qv = -qv;
      rv = pv[i] - qv;
      if (rv > hi) begin
        rv = hi;
        res.sat = 1'b1;
      end
      if (rv < lo) begin
        rv = lo;
        res.sat = 1'b1;
      end
      outc[i] = rv[CW-1:0];
    end
    res.x = outc[0];
    res.y = outc[1];
    res.z = outc[2];
    return res;
  endfunction

  function automatic coord_t pick_extreme();
    return $urandom_range(1) ? CMAX : CMIN;
  endfunction

  function automatic coord_t pick_normal_part();
    case ($urandom_range(7))
      0: return '0;
      1: return coord_t'(int'($urandom_range(4)) - 2);
      2: return $urandom_range(1) ? ONE : -ONE;
      3: return coord_t'(int'($urandom_range(2097152)) - 1048576);
      4: return pick_extreme();
      default: return $urandom;
    endcase
  endfunction

  function automatic coord_t pick_anchor_part();
    case ($urandom_range(5))
      0: return '0;
      1: return pick_extreme();
      2: return coord_t'(int'($urandom_range(200)) - 100) <<< FRAC_BITS;
      default: return $urandom;
    endcase
  endfunction

  function automatic plane_t random_plane(int ph);
    plane_t pl;
    pl.nx = pick_normal_part();
    pl.ny = pick_normal_part();
    pl.nz = pick_normal_part();
    pl.ax = pick_anchor_part();
    pl.ay = pick_anchor_part();
    pl.az = pick_anchor_part();
    pl.mode = ph[0];
    // one phase on a zero normal, so passthrough shows up in the random mix
    if (ph == 8) begin
      pl.nx = '0;
      pl.ny = '0;
      pl.nz = '0;
    end
    return pl;
  endfunction

  function automatic coord_t pick_coord(coord_t near);
    case ($urandom_range(6))
      0: return pick_extreme();
      1: return near + coord_t'(int'($urandom_range(512)) - 256);
      2: return coord_t'(int'($urandom_range(2000)) - 1000) <<< (FRAC_BITS - 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic vertex_out_t mk_out(coord_t x, coord_t y, coord_t z, logic sat,
                                         logic deg);
    vertex_out_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    v.sat = sat;
    v.deg = deg;
    return v;
  endfunction

  function automatic plane_t mk_plane(coord_t nx, coord_t ny, coord_t nz, coord_t ax,
                                      coord_t ay, coord_t az, logic mode);
    plane_t pl;
    pl.nx = nx;
    pl.ny = ny;
    pl.nz = nz;
    pl.ax = ax;
    pl.ay = ay;
    pl.az = az;
    pl.mode = mode;
    return pl;
  endfunction

  task automatic add_row(int sel, coord_t x, coord_t y, coord_t z, bit known,
                         vertex_out_t want);
    vector_row_t r;
    r.plane_sel = sel;
    r.x = x;
    r.y = y;
    r.z = z;
    r.known = known;
    r.want = want;
    vector_table.insert(vector_table.size(), r);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_plane(plane_t pl);
    write_reg(REG_NORMAL_X, pl.nx);
    write_reg(REG_NORMAL_Y, pl.ny);
    write_reg(REG_NORMAL_Z, pl.nz);
    write_reg(REG_ANCHOR_X, pl.ax);
    write_reg(REG_ANCHOR_Y, pl.ay);
    write_reg(REG_ANCHOR_Z, pl.az);
    write_reg(REG_PROJECT_MODE, DATA_W'(pl.mode));
    plane = pl;
  endtask

  task automatic send_vertex(coord_t x, coord_t y, coord_t z, bit known, vertex_out_t want);
    while (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_vertex_x <= x;
    in_vertex_y <= y;
    in_vertex_z <= z;
    row_known   <= known;
    row_want    <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid, let the last accepted beat land, then drain
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (moved_vertices.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    hold_left = 0;
    forever begin
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (out_hold_pct != 0) && ($urandom_range(99) < out_hold_pct);
      end
      @(posedge clk);
    end
  end

  // check the result beat first, then record the expectation of the input beat
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got_v = mk_out(out_x, out_y, out_z, out_saturated, out_degenerate_plane);
        if (moved_vertices.size() == 0) begin
          if (n_bad < 10) $display("unexpected result beat %h %h %h sat %b deg %b",
                                   got_v.x, got_v.y, got_v.z, got_v.sat, got_v.deg);
          n_bad++;
        end else begin
          want_v = moved_vertices.pop_front();
          if (got_v !== want_v) begin
            if (n_bad < 10) begin
              $display("result mismatch: expected %h %h %h sat %b deg %b",
                       want_v.x, want_v.y, want_v.z, want_v.sat, want_v.deg);
              $display("                 actual   %h %h %h sat %b deg %b",
                       got_v.x, got_v.y, got_v.z, got_v.sat, got_v.deg);
            end
            n_bad++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (row_known) moved_vertices.insert(moved_vertices.size(), row_want);
        else moved_vertices.insert(moved_vertices.size(),
          reflect_or_project(plane, in_vertex_x, in_vertex_y, in_vertex_z));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("plane_reflect_project_core: mismatch");
    $finish;
  end

  initial begin
    int          cur_sel;
    vertex_out_t none;
    plane_t      pl;
    none = '0;
    n_bad = 0;
    hold_off_req = 1'b0;
    in_gap_pct = 26;
    out_hold_pct = 26;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_vertex_x <= '0;
    in_vertex_y <= '0;
    in_vertex_z <= '0;
    row_known   <= 1'b0;
    row_want    <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    plane = mk_plane('0, '0, NORMAL_Z_RST, '0, '0, '0, 1'b0);

    dir_planes[0] = plane;
    dir_planes[1] = mk_plane('0, '0, '0, 32'sd5, 32'sd6, 32'sd7, 1'b0);
    dir_planes[2] = mk_plane(32'sd1, 32'sd1, '0, '0, '0, '0, 1'b1);
    dir_planes[3] = mk_plane('0, '0, ONE, '0, '0, 32'sh30000, 1'b1);
    dir_planes[4] = mk_plane(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b0);
    dir_planes[5] = mk_plane(CMAX, CMIN, 32'sd1, CMIN, '0, CMAX, 1'b1);

    // reset plane is z = 0, reflect: z flips sign
    add_row(0, '0, '0, '0, 1, mk_out('0, '0, '0, 0, 0));
    add_row(0, CMAX, CMIN, CMAX, 1, mk_out(CMAX, CMIN, -CMAX, 0, 0));
    add_row(0, 32'sd1, -32'sd1, CMIN, 1, mk_out(32'sd1, -32'sd1, CMAX, 1, 0));
    add_row(0, ONE, -ONE, 32'sh28000, 1, mk_out(ONE, -ONE, -32'sh28000, 0, 0));
    // zero normal: pass through
    add_row(1, CMIN, CMAX, 32'sh12345678, 1, mk_out(CMIN, CMAX, 32'sh12345678, 0, 1));
    add_row(1, CMAX, CMIN, -32'sd1, 1, mk_out(CMAX, CMIN, -32'sd1, 0, 1));
    // half-way offsets round away from zero on both sides of the plane
    add_row(2, 32'sd1, '0, '0, 1, mk_out('0, -32'sd1, '0, 0, 0));
    add_row(2, -32'sd1, '0, '0, 1, mk_out('0, 32'sd1, '0, 0, 0));
    add_row(2, 32'sd3, '0, 32'sd5, 1, mk_out(32'sd1, -32'sd2, 32'sd5, 0, 0));
    add_row(2, CMAX, CMIN, CMAX, 0, none);
    // project onto z = 3.0
    add_row(3, CMIN, CMAX, CMIN, 1, mk_out(CMIN, CMAX, 32'sh30000, 0, 0));
    add_row(3, 32'sd7, -32'sd7, CMAX, 1, mk_out(32'sd7, -32'sd7, 32'sh30000, 0, 0));
    // extreme normals and anchors
    add_row(4, CMAX, CMAX, CMAX, 1, mk_out(CMAX, CMAX, CMAX, 0, 0));
    add_row(4, CMIN, CMIN, CMIN, 0, none);
    add_row(4, '0, '0, '0, 0, none);
    add_row(4, CMIN, CMAX, '0, 0, none);
    add_row(5, CMIN, '0, CMAX, 1, mk_out(CMIN, '0, CMAX, 0, 0));
    add_row(5, CMAX, CMAX, CMAX, 0, none);
    add_row(5, CMIN, CMIN, CMIN, 0, none);
    add_row(5, 32'sh12345678, -32'sh2345678, '0, 0, none);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_sel = 0;
    foreach (vector_table[i]) begin
      if (vector_table[i].plane_sel != cur_sel) begin
        drain_all();
        cur_sel = vector_table[i].plane_sel;
        program_plane(dir_planes[cur_sel]);
      end
      send_vertex(vector_table[i].x, vector_table[i].y, vector_table[i].z,
                  vector_table[i].known, vector_table[i].want);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_all();
      pl = random_plane(ph);
      program_plane(pl);
      in_gap_pct = (ph == 2) ? 0 : 26;
      out_hold_pct = (ph == 2) ? 0 : 26;
      // hold the result side off while beats keep coming, to back the pipe up
      if (ph == 5) hold_off_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(3) == 0)
          send_vertex(pl.ax + coord_t'(int'($urandom_range(64)) - 32),
                      pl.ay + coord_t'(int'($urandom_range(64)) - 32),
                      pl.az + coord_t'(int'($urandom_range(64)) - 32), 0, none);
        else
          send_vertex(pick_coord(pl.ax), pick_coord(pl.ay), pick_coord(pl.az), 0, none);
      end
    end

    drain_all();
    repeat (60) @(posedge clk);
    if (moved_vertices.size() != 0) n_bad++;
    if (n_bad == 0) begin
      $display("plane_reflect_project_core: match");
    end else begin
      $display("plane_reflect_project_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/prp_pkg.sv
rtl/prp_div_lane.sv
rtl/plane_reflect_project_core.sv
tb/tb_top.sv
